// File: sv/cbt_pkg.sv
package cbt_pkg;

   // table depth default and prefix width
   localparam int ENTRIES_DEFAULT = 64;
   localparam int FULL_PREFIX = 32;

   // request modes
   localparam logic [1:0] MODE_ADD    = 2'd0;
   localparam logic [1:0] MODE_REMOVE = 2'd1;
   localparam logic [1:0] MODE_LOOKUP = 2'd2;
   localparam logic [1:0] MODE_CLEAR  = 2'd3;

   // result codes
   localparam logic [1:0] RES_DONE     = 2'd0;
   localparam logic [1:0] RES_REJECTED = 2'd1;
   localparam logic [1:0] RES_FULL     = 2'd2;

   // lookup answers
   localparam logic [1:0] BAN_NONE      = 2'd0;
   localparam logic [1:0] BAN_PERMANENT = 2'd1;
   localparam logic [1:0] BAN_TIMED     = 2'd2;

   // one stored ban
   typedef struct packed {
      logic [31:0] address;
      logic [5:0]  length;
      logic [31:0] expiry;
   } ban_entry_type;

   // sequencer states
   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_WALK = 3'b010,
      ST_RESP = 3'b100
   } state_type;

   // top prefix bits of addr and base agree over len bits
   function automatic logic prefix_match(
      input logic [31:0] addr,
      input logic [31:0] base,
      input logic [5:0]  len
   );
      logic [31:0] mask;
      if (len == 6'd0) begin
         mask = '0;
      end else if (len >= 6'(FULL_PREFIX)) begin
         mask = '1;
      end else begin
         mask = ~(32'hFFFF_FFFF >> len);
      end
      return ((addr ^ base) & mask) == 32'd0;
   endfunction

endpackage

// File: sv/cidr_ban_table.sv
// Ordered table of IPv4 prefix bans with expiry. A request carries a mode
// (add, remove, lookup, clear) and gets exactly one response. For add and
// clear the request is accepted and the response is registered in the next
// cycle. Remove and lookup on a non-empty table walk the stored bans in
// order through a table memory with one write port and one registered read
// port, one entry compared per cycle, and close gaps left by deleted entries
// during the same walk. The walk stops early once a lookup finds a live ban
// and nothing had to be moved. No new request is accepted until the response
// has been taken. Table contents need no clearing after reset; only the
// state, the entry count and the walk flags are reset.
module cidr_ban_table
   import cbt_pkg::*;
#(
   parameter int ENTRIES = ENTRIES_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_mode,
   input  logic [31:0] req_address,
   input  logic [5:0]  req_prefix_len,
   input  logic [31:0] req_expiry,
   input  logic [31:0] req_now,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_result_code,
   output logic [1:0]  rsp_ban_state
);

   localparam int CW = $clog2(ENTRIES + 1);
   localparam int IW = $clog2(ENTRIES);
   localparam logic [CW-1:0] ENTRIES_CNT = CW'(ENTRIES);

   // table memory
   ban_entry_type ban_mem [ENTRIES];
   ban_entry_type rd_data_ff;
   logic          mem_we;
   logic [IW-1:0] mem_waddr;
   ban_entry_type mem_wdata;

   // control state
   state_type     state_ff, state_in;
   logic [CW-1:0] entry_count_ff, entry_count_in;
   logic [CW-1:0] rd_idx_ff, rd_idx_in;
   logic [CW-1:0] chk_idx_ff, chk_idx_in;
   logic [CW-1:0] wr_idx_ff, wr_idx_in;
   logic          fetched_ff, fetched_in;
   logic          found_ff, found_in;

   // latched request
   logic [1:0]  mode_ff, mode_in;
   logic [31:0] address_ff, address_in;
   logic [5:0]  prefix_len_ff, prefix_len_in;
   logic [31:0] now_ff, now_in;

   // response register
   logic [1:0] result_code_ff, result_code_in;
   logic [1:0] ban_state_ff, ban_state_in;

   logic req_accept;
   logic rsp_accept;
   logic add_bad;

   // walk compare
   logic hit_exact;
   logic hit_prefix;
   logic expired;
   logic drop;
   logic hit_live;
   logic [CW-1:0] chk_next;
   logic [CW-1:0] wr_next;

   assign req_accept = req_valid && !req_stall;
   assign rsp_accept = rsp_valid && !rsp_stall;
   assign req_stall  = (state_ff != ST_IDLE);
   assign rsp_valid  = (state_ff == ST_RESP);
   assign rsp_result_code = result_code_ff;
   assign rsp_ban_state   = ban_state_ff;

   assign add_bad = (req_address == 32'd0) || (req_prefix_len == 6'd0) ||
                    (req_prefix_len > 6'(FULL_PREFIX));

   // entry under examination
   assign hit_exact  = (rd_data_ff.address == address_ff) &&
                       (rd_data_ff.length == prefix_len_ff);
   assign hit_prefix = prefix_match(address_ff, rd_data_ff.address, rd_data_ff.length);
   assign expired    = (rd_data_ff.expiry != 32'd0) && (now_ff >= rd_data_ff.expiry);
   assign drop       = !found_ff && ((mode_ff == MODE_REMOVE) ? hit_exact
                                                              : (hit_prefix && expired));
   assign hit_live   = !found_ff && (mode_ff == MODE_LOOKUP) && hit_prefix && !expired;
   assign chk_next   = chk_idx_ff + CW'(1);
   assign wr_next    = drop ? wr_idx_ff : wr_idx_ff + CW'(1);

   // sequencer
   always_comb begin
      state_in       = state_ff;
      entry_count_in = entry_count_ff;
      rd_idx_in      = rd_idx_ff;
      chk_idx_in     = chk_idx_ff;
      wr_idx_in      = wr_idx_ff;
      fetched_in     = 1'b0;
      found_in       = found_ff;
      mode_in        = mode_ff;
      address_in     = address_ff;
      prefix_len_in  = prefix_len_ff;
      now_in         = now_ff;
      result_code_in = result_code_ff;
      ban_state_in   = ban_state_ff;
      mem_we         = 1'b0;
      mem_waddr      = entry_count_ff[IW-1:0];
      mem_wdata      = '{address: req_address, length: req_prefix_len, expiry: req_expiry};

      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               mode_in        = req_mode;
               address_in     = req_address;
               prefix_len_in  = req_prefix_len;
               now_in         = req_now;
               result_code_in = RES_DONE;
               ban_state_in   = BAN_NONE;
               rd_idx_in      = '0;
               chk_idx_in     = '0;
               wr_idx_in      = '0;
               found_in       = 1'b0;
               state_in       = ST_RESP;
               unique case (req_mode)
                  MODE_ADD: begin
                     if (add_bad) begin
                        result_code_in = RES_REJECTED;
                     end else if (entry_count_ff >= ENTRIES_CNT) begin
                        result_code_in = RES_FULL;
                     end else begin
                        mem_we         = 1'b1;
                        entry_count_in = entry_count_ff + CW'(1);
                     end
                  end
                  MODE_REMOVE: begin
                     if (entry_count_ff == '0) begin
                        result_code_in = RES_REJECTED;
                     end else begin
                        state_in = ST_WALK;
                     end
                  end
                  MODE_LOOKUP: begin
                     if (entry_count_ff != '0) begin
                        state_in = ST_WALK;
                     end
                  end
                  MODE_CLEAR: begin
                     entry_count_in = '0;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_WALK: begin
            // read one entry ahead of the compare
            fetched_in = (rd_idx_ff < entry_count_ff);
            if (rd_idx_ff < entry_count_ff) begin
               rd_idx_in = rd_idx_ff + CW'(1);
            end
            if (fetched_ff) begin
               // keep surviving entries packed toward the front
               if (!drop && (wr_idx_ff != chk_idx_ff)) begin
                  mem_we    = 1'b1;
                  mem_waddr = wr_idx_ff[IW-1:0];
                  mem_wdata = rd_data_ff;
               end
               if ((mode_ff == MODE_REMOVE) && drop) begin
                  found_in = 1'b1;
               end
               if (hit_live) begin
                  found_in     = 1'b1;
                  ban_state_in = (rd_data_ff.expiry == 32'd0) ? BAN_PERMANENT : BAN_TIMED;
               end
               wr_idx_in  = wr_next;
               chk_idx_in = chk_next;
               if ((chk_next == entry_count_ff) || (hit_live && (wr_next == chk_next))) begin
                  entry_count_in = entry_count_ff - (chk_next - wr_next);
                  if (mode_ff == MODE_REMOVE) begin
                     result_code_in = (found_ff || drop) ? RES_DONE : RES_REJECTED;
                  end
                  state_in = ST_RESP;
               end
            end
         end
         ST_RESP: begin
            if (rsp_accept) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         entry_count_ff <= '0;
         fetched_ff     <= 1'b0;
         found_ff       <= 1'b0;
      end else begin
         state_ff       <= state_in;
         entry_count_ff <= entry_count_in;
         fetched_ff     <= fetched_in;
         found_ff       <= found_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      rd_idx_ff      <= rd_idx_in;
      chk_idx_ff     <= chk_idx_in;
      wr_idx_ff      <= wr_idx_in;
      mode_ff        <= mode_in;
      address_ff     <= address_in;
      prefix_len_ff  <= prefix_len_in;
      now_ff         <= now_in;
      result_code_ff <= result_code_in;
      ban_state_ff   <= ban_state_in;
   end

   // table memory, one write and one registered read
   always_ff @(posedge clock) begin
      if (mem_we) begin
         ban_mem[mem_waddr] <= mem_wdata;
      end
      rd_data_ff <= ban_mem[rd_idx_ff[IW-1:0]];
   end

   // checks
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      entry_count_ff <= ENTRIES_CNT)
      else $error("entry count above table depth");

   a_pack_order: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_WALK) |-> (wr_idx_ff <= chk_idx_ff))
      else $error("compaction write pointer ahead of compare pointer");

   a_walk_nonempty: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_WALK) |-> (entry_count_ff != '0))
      else $error("walk over an empty table");

   a_full_code: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_result_code == RES_FULL)) |-> (entry_count_ff == ENTRIES_CNT))
      else $error("table full reported on a table with room");

   a_state_code: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_ban_state != BAN_NONE)) |->
         (rsp_result_code == RES_DONE && mode_ff == MODE_LOOKUP))
      else $error("ban answer on a request that is not a lookup");

endmodule
